>>> sv/bpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and fixed-point helpers for the Boris pusher.
// ----------------------------------------------------------------------------
package bpp_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [47:0] wide_t;

  localparam logic REG_CHARGE_TO_MASS = 1'b0;
  localparam logic REG_TIME_STEP      = 1'b1;

  localparam int DIV_BITS   = 48;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic signed [63:0] QONE  = 64'sd65536;
  localparam logic signed [63:0] NLIM  = 64'sd140737488355327;

  // Input request as seen by the front end.
  typedef struct packed {
    logic        valid;
    q_t [2:0]    x;
    q_t [2:0]    v;
    q_t [2:0]    e;
    q_t [2:0]    b;
  } req_t;

  // Half kick and rotation vector.
  typedef struct packed {
    logic        valid;
    q_t [2:0]    x;
    q_t [2:0]    u;
    q_t [2:0]    h;
    q_t [2:0]    k;
  } kick_t;

  // State carried through the divider.
  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [31:0] den;
    logic [31:0] rem;
    logic [47:0] quo;
    q_t [2:0]    x;
    q_t [2:0]    k;
  } divs_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > MAX32) return q_t'(MAX32);
    if (v < MIN32) return q_t'(MIN32);
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] rnd17(input logic signed [63:0] p);
    return (p + 64'sd65536) >>> 17;
  endfunction

endpackage

>>> sv/boris_particle_push.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_particle_push
// Fully pipelined Boris pusher, signed Q16.16, one particle per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Write charge_to_mass (index 0) and time_step (index 1) through cfg_we /
//   cfg_addr / cfg_data while the pipeline is empty; both reset to zero.
//   Present one particle (position, velocity, E and B) with start high; a
//   request is taken on every edge with start high, since busy stays low.
//   Results appear on new_pos_* / new_vel_* for one cycle with done high,
//   after passing through 22 register stages, in request
//   order, and are taken at the edge that ends that cycle.
//   Throughput is one particle per cycle: front end 3 stages, rotation 4,
//   a 12-stage restoring divider (4 quotient bits a stage, 48 bits) and
//   3 stages for the second kick and the drift. The divider is the deepest
//   part of the pipeline. Each axis has its own rotation and divider lane.
//   Synchronous reset clears all valid bits; requests in flight are dropped.
//   The receiver cannot stall, so done simply follows the pipeline.
// ----------------------------------------------------------------------------
module boris_particle_push import bpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  q_t          pos_x,
  input  q_t          pos_y,
  input  q_t          pos_z,
  input  q_t          vel_x,
  input  q_t          vel_y,
  input  q_t          vel_z,
  input  q_t          e_x,
  input  q_t          e_y,
  input  q_t          e_z,
  input  q_t          b_x,
  input  q_t          b_y,
  input  q_t          b_z,
  output logic        done,
  output q_t          new_pos_x,
  output q_t          new_pos_y,
  output q_t          new_pos_z,
  output q_t          new_vel_x,
  output q_t          new_vel_y,
  output q_t          new_vel_z
);

  q_t          charge_to_mass;
  logic [30:0] time_step;

  req_t        req;
  kick_t       kick;
  divs_t       dchain [3][DIV_STAGES + 1];

  logic [2:0]  b_valid, b_neg;
  wide_t [2:0] b_quo;
  q_t [2:0]    b_pos, b_k, npos, nvel;

  // The pipeline never holds off a request.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_to_mass <= '0;
      time_step      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CHARGE_TO_MASS: charge_to_mass <= cfg_data;
        REG_TIME_STEP:      time_step      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Pack the request.
  always_comb begin
    req.valid = start & ~busy;
    req.x = {pos_z, pos_y, pos_x};
    req.v = {vel_z, vel_y, vel_x};
    req.e = {e_z, e_y, e_x};
    req.b = {b_z, b_y, b_x};
  end

  bpp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .charge_to_mass (charge_to_mass),
    .time_step      (time_step),
    .req            (req),
    .kick           (kick)
  );

  // One rotation lane and one divider chain per axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    bpp_rotate_lane #(.AXIS(a)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .kick (kick),
      .divs (dchain[a][0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      bpp_div_stage u_div (
        .clk  (clk),
        .rst  (rst),
        .din  (dchain[a][s]),
        .dout (dchain[a][s + 1])
      );
    end

    // Lanes are axis-rotated, so their own axis sits in element 0.
    assign b_valid[a] = dchain[a][DIV_STAGES].valid;
    assign b_neg[a]   = dchain[a][DIV_STAGES].neg;
    assign b_quo[a]   = dchain[a][DIV_STAGES].quo;
    assign b_pos[a]   = dchain[a][DIV_STAGES].x[0];
    assign b_k[a]     = dchain[a][DIV_STAGES].k[0];
  end

  bpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .time_step (time_step),
    .in_valid  (b_valid),
    .in_neg    (b_neg),
    .in_quo    (b_quo),
    .in_x      (b_pos),
    .in_k      (b_k),
    .done      (done),
    .new_pos   (npos),
    .new_vel   (nvel)
  );

  assign new_pos_x = npos[0];
  assign new_pos_y = npos[1];
  assign new_pos_z = npos[2];
  assign new_vel_x = nvel[0];
  assign new_vel_y = nvel[1];
  assign new_vel_z = nvel[2];

endmodule

>>> sv/bpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_front
// Acceleration, rotation vector, half kick: three register stages.
// ----------------------------------------------------------------------------
module bpp_front import bpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_t          charge_to_mass,
  input  logic [30:0] time_step,
  input  req_t        req,
  output kick_t       kick
);

  q_t [2:0] s1_a, s1_w, s1_x, s1_v;
  q_t [2:0] s2_k, s2_h, s2_x, s2_v;
  logic     s1_valid, s2_valid;
  logic signed [31:0] dt_s;

  assign dt_s = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      kick.valid <= 1'b0;
    end else begin
      s1_valid   <= req.valid;
      s2_valid   <= s1_valid;
      kick.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] pa, pw, pk, ph, su;
    for (int i = 0; i < 3; i++) begin
      // stage 1: a = (q/m)E, omega = -(q/m)B
      pa = $signed(charge_to_mass) * $signed(req.e[i]);
      pw = $signed(charge_to_mass) * $signed(req.b[i]);
      s1_a[i] <= sat32(rnd16(pa));
      s1_w[i] <= sat32(rnd16(-pw));
      s1_x[i] <= req.x[i];
      s1_v[i] <= req.v[i];
      // stage 2: k = (dt/2)a, h = -(dt/2)omega
      pk = dt_s * $signed(s1_a[i]);
      ph = dt_s * $signed(s1_w[i]);
      s2_k[i] <= sat32(rnd17(pk));
      s2_h[i] <= sat32(rnd17(-ph));
      s2_x[i] <= s1_x[i];
      s2_v[i] <= s1_v[i];
      // stage 3: u = v + k
      su = 64'($signed(s2_v[i])) + 64'($signed(s2_k[i]));
      kick.u[i] <= sat32(su);
      kick.h[i] <= s2_h[i];
      kick.k[i] <= s2_k[i];
      kick.x[i] <= s2_x[i];
    end
  end

endmodule

>>> sv/bpp_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_rotate
// Rotation numerator and denominator, divider setup: four register stages.
// ----------------------------------------------------------------------------
module bpp_rotate import bpp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  kick_t kick,
  output divs_t divs
);

  // stage 4
  logic         s4_valid;
  wide_t [2:0]  s4_hh, s4_uh, s4_c1, s4_c2;
  q_t [2:0]     s4_u, s4_h, s4_x, s4_k;
  // stage 5
  logic         s5_valid;
  logic [30:0]  s5_h2;
  q_t           s5_uh;
  logic signed [48:0] s5_cr [3];
  q_t [2:0]     s5_u, s5_h, s5_x, s5_k;
  // stage 6
  logic         s6_valid;
  wide_t [2:0]  s6_p1, s6_p2;
  logic signed [48:0] s6_cr [3];
  logic [31:0]  s6_den;
  q_t [2:0]     s6_x, s6_k;
  // stage 7 lane select
  logic signed [63:0] t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      s6_valid   <= 1'b0;
      divs.valid <= 1'b0;
    end else begin
      s4_valid   <= kick.valid;
      s5_valid   <= s4_valid;
      s6_valid   <= s5_valid;
      divs.valid <= s6_valid;
    end
  end

  // stage 4: rounded products of u and h
  always_ff @(posedge clk) begin
    logic signed [63:0] p;
    for (int i = 0; i < 3; i++) begin
      p = $signed(kick.h[i]) * $signed(kick.h[i]);
      s4_hh[i] <= wide_t'(rnd16(p));
      p = $signed(kick.u[i]) * $signed(kick.h[i]);
      s4_uh[i] <= wide_t'(rnd16(p));
      p = $signed(kick.u[(i + 1) % 3]) * $signed(kick.h[(i + 2) % 3]);
      s4_c1[i] <= wide_t'(rnd16(p));
      p = $signed(kick.h[(i + 1) % 3]) * $signed(kick.u[(i + 2) % 3]);
      s4_c2[i] <= wide_t'(rnd16(p));
    end
    s4_u <= kick.u;
    s4_h <= kick.h;
    s4_x <= kick.x;
    s4_k <= kick.k;
  end

  // stage 5: |h|^2, u.h, cross product
  always_ff @(posedge clk) begin
    logic signed [63:0] sh, su;
    sh = 64'($signed(s4_hh[0])) + 64'($signed(s4_hh[1])) + 64'($signed(s4_hh[2]));
    su = 64'($signed(s4_uh[0])) + 64'($signed(s4_uh[1])) + 64'($signed(s4_uh[2]));
    s5_h2 <= (sh > MAX32) ? 31'h7FFFFFFF : sh[30:0];
    s5_uh <= sat32(su);
    for (int i = 0; i < 3; i++) begin
      s5_cr[i] <= 49'($signed(s4_c1[i])) - 49'($signed(s4_c2[i]));
    end
    s5_u <= s4_u;
    s5_h <= s4_h;
    s5_x <= s4_x;
    s5_k <= s4_k;
  end

  // stage 6: (1-|h|^2)u, (u.h)h and the denominator 1+|h|^2
  always_ff @(posedge clk) begin
    logic signed [32:0] one;
    logic signed [63:0] p;
    one = 33'sd65536 - $signed({2'b00, s5_h2});
    for (int i = 0; i < 3; i++) begin
      p = one * $signed(s5_u[i]);
      s6_p1[i] <= wide_t'(rnd16(p));
      p = $signed(s5_uh) * $signed(s5_h[i]);
      s6_p2[i] <= wide_t'(rnd16(p));
      s6_cr[i] <= s5_cr[i];
    end
    s6_den <= 32'd65536 + {1'b0, s5_h2};
    s6_x   <= s5_x;
    s6_k   <= s5_k;
  end

  // stage 7: numerator, clamp, form the dividend for element 0 of this lane
  // (each axis lane has its own copy of this stage; element 0 feeds this divider)
  assign t0 = 64'($signed(s6_p1[0])) + 64'sd2 * (64'(s6_cr[0]) + 64'($signed(s6_p2[0])));

  always_ff @(posedge clk) begin
    logic signed [63:0] tc, mag;
    logic [63:0]        n;
    tc = t0;
    if (tc > NLIM)  tc = NLIM;
    if (tc < -NLIM) tc = -NLIM;
    mag = (tc < 0) ? -tc : tc;
    n   = ({17'd0, mag[46:0]} << 16) + {33'd0, s6_den[31:1]};
    divs.neg <= tc < 0;
    divs.den <= s6_den;
    divs.rem <= {16'd0, n[63:48]};
    divs.quo <= n[47:0];
    divs.x   <= s6_x;
    divs.k   <= s6_k;
  end

endmodule

>>> sv/bpp_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_div_stage
// One registered stage of the restoring divider: DIV_STEP quotient bits.
// ----------------------------------------------------------------------------
module bpp_div_stage import bpp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  divs_t din,
  output divs_t dout
);

  logic [31:0] rem_next;
  logic [47:0] quo_next;

  always_comb begin
    logic [32:0] r;
    rem_next = din.rem;
    quo_next = din.quo;
    for (int s = 0; s < DIV_STEP; s++) begin
      r        = {rem_next, quo_next[47]};
      quo_next = {quo_next[46:0], 1'b0};
      if (r >= {1'b0, din.den}) begin
        r           = r - {1'b0, din.den};
        quo_next[0] = 1'b1;
      end
      rem_next = r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.neg <= din.neg;
    dout.den <= din.den;
    dout.rem <= rem_next;
    dout.quo <= quo_next;
    dout.x   <= din.x;
    dout.k   <= din.k;
  end

endmodule

>>> sv/bpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_back
// Second half kick and position update: three register stages.
// ----------------------------------------------------------------------------
module bpp_back import bpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] time_step,
  input  logic [2:0]  in_valid,
  input  logic [2:0]  in_neg,
  input  wide_t [2:0] in_quo,
  input  q_t [2:0]    in_x,
  input  q_t [2:0]    in_k,
  output logic        done,
  output q_t [2:0]    new_pos,
  output q_t [2:0]    new_vel
);

  logic        f1_valid, f2_valid;
  q_t [2:0]    f1_nv, f1_x, f2_nv, f2_x;
  wide_t [2:0] f2_p;
  logic signed [31:0] dt_s;

  assign dt_s = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      f1_valid <= in_valid[0];
      f2_valid <= f1_valid;
      done     <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] q, uu, p;
    for (int i = 0; i < 3; i++) begin
      q  = $signed({16'd0, in_quo[i]});
      uu = 64'($signed(sat32(in_neg[i] ? -q : q)));
      f1_nv[i] <= sat32(uu + 64'($signed(in_k[i])));
      f1_x[i]  <= in_x[i];
      p = dt_s * $signed(f1_nv[i]);
      f2_p[i]  <= wide_t'(rnd16(p));
      f2_nv[i] <= f1_nv[i];
      f2_x[i]  <= f1_x[i];
      new_pos[i] <= sat32(64'($signed(f2_x[i])) + 64'($signed(f2_p[i])));
      new_vel[i] <= f2_nv[i];
    end
  end

endmodule

>>> sv/bpp_rotate_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_rotate_lane
// Per-axis rotation front: rotates the kick vector so that the chosen axis
// lands in element 0 of this axis's own rotation pipeline.
// ----------------------------------------------------------------------------
module bpp_rotate_lane import bpp_pkg::*; #(
  parameter int AXIS = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  kick_t kick,
  output divs_t divs
);

  kick_t rk;

  // Cyclic axis shift keeps every cross term in the same place.
  always_comb begin
    rk.valid = kick.valid;
    for (int i = 0; i < 3; i++) begin
      rk.x[i] = kick.x[(i + AXIS) % 3];
      rk.u[i] = kick.u[(i + AXIS) % 3];
      rk.h[i] = kick.h[(i + AXIS) % 3];
      rk.k[i] = kick.k[(i + AXIS) % 3];
    end
  end

  bpp_rotate u_rot (
    .clk  (clk),
    .rst  (rst),
    .kick (rk),
    .divs (divs)
  );

endmodule

>>> verif/boris_particle_push_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_particle_push_chk
// Watches the request, configuration and result ports of the Boris pusher,
// computes the expected new position and velocity of each accepted particle
// and compares every done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module boris_particle_push_chk import bpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  q_t          pos_x,
  input  q_t          pos_y,
  input  q_t          pos_z,
  input  q_t          vel_x,
  input  q_t          vel_y,
  input  q_t          vel_z,
  input  q_t          e_x,
  input  q_t          e_y,
  input  q_t          e_z,
  input  q_t          b_x,
  input  q_t          b_y,
  input  q_t          b_z,
  input  logic        done,
  input  q_t          new_pos_x,
  input  q_t          new_pos_y,
  input  q_t          new_pos_z,
  input  q_t          new_vel_x,
  input  q_t          new_vel_y,
  input  q_t          new_vel_z,
  output int          errors,
  output int          pending
);

  typedef logic signed [63:0] s64_t;
  typedef struct packed {
    q_t [2:0] pos;
    q_t [2:0] vel;
  } particle_t;

  s64_t      qm_ratio;
  s64_t      dt_step;
  particle_t expected_pushes[$];

  function automatic s64_t clamp32(input s64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round half up: arithmetic shift is a floor.
  function automatic s64_t round_shr(input s64_t x, input int sh);
    s64_t y;
    y = x + (64'sd1 <<< (sh - 1));
    return y >>> sh;
  endfunction

  function automatic s64_t fxmul(input s64_t a, input s64_t b);
    return round_shr(a * b, 16);
  endfunction

  // Rotation quotient: n * 2^16 / d, half away from zero.
  function automatic s64_t fxdiv(input s64_t n, input s64_t d);
    s64_t        lim;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    lim = (64'sd1 <<< 47) - 1;
    neg = n < 0;
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
    mag = (neg ? -n : n) << 16;
    q = (mag + d / 2) / d;
    return neg ? -s64_t'(q) : s64_t'(q);
  endfunction

  function automatic particle_t boris_push(input q_t p[3], input q_t vin[3],
                                          input q_t ef[3], input q_t bf[3]);
    s64_t      acc, om, k[3], u[3], h[3], nv;
    s64_t      h2, uh, one_m, den, num, rot;
    particle_t r;
    int        j, m;
    h2 = 0;
    uh = 0;
    for (int i = 0; i < 3; i++) begin
      acc  = clamp32(fxmul(qm_ratio, s64_t'(ef[i])));
      om   = clamp32(round_shr(-(qm_ratio * s64_t'(bf[i])), 16));
      k[i] = clamp32(round_shr(dt_step * acc, 17));
      u[i] = clamp32(s64_t'(vin[i]) + k[i]);
      h[i] = clamp32(round_shr(-(dt_step * om), 17));
    end
    for (int i = 0; i < 3; i++) begin
      h2 += fxmul(h[i], h[i]);
      uh += fxmul(u[i], h[i]);
    end
    if (h2 > 64'sd2147483647) h2 = 64'sd2147483647;
    uh = clamp32(uh);
    one_m = 64'sd65536 - h2;
    den = 64'sd65536 + h2;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      m = (i + 2) % 3;
      num = fxmul(one_m, u[i])
          + 2 * (fxmul(u[j], h[m]) - fxmul(h[j], u[m]) + fxmul(uh, h[i]));
      rot = clamp32(fxdiv(num, den));
      nv = clamp32(rot + k[i]);
      r.vel[i] = q_t'(nv);
      r.pos[i] = q_t'(clamp32(s64_t'(p[i]) + fxmul(dt_step, nv)));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input q_t exp_v, input q_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = expected_pushes.size();

  always @(posedge clk) begin
    particle_t exp_p;
    if (rst) begin
      qm_ratio <= 0;
      dt_step <= 0;
      errors <= 0;
      expected_pushes.delete();
    end else begin
      // Compare before enqueueing: a result always comes from an older request, as the pipeline is registered.
      if (done) begin
        if (expected_pushes.size() == 0) begin
          $display("%0t unexpected result, nothing pending", $realtime);
          errors++;
        end else begin
          exp_p = expected_pushes.pop_front();
          check_field("new_pos_x", exp_p.pos[0], new_pos_x);
          check_field("new_pos_y", exp_p.pos[1], new_pos_y);
          check_field("new_pos_z", exp_p.pos[2], new_pos_z);
          check_field("new_vel_x", exp_p.vel[0], new_vel_x);
          check_field("new_vel_y", exp_p.vel[1], new_vel_y);
          check_field("new_vel_z", exp_p.vel[2], new_vel_z);
        end
      end
      if (start && !busy)
        expected_pushes.push_back(boris_push('{pos_x, pos_y, pos_z},
            '{vel_x, vel_y, vel_z}, '{e_x, e_y, e_z}, '{b_x, b_y, b_z}));
      if (cfg_we) begin
        if (cfg_addr == REG_CHARGE_TO_MASS) qm_ratio <= s64_t'(signed'(cfg_data));
        else dt_step <= s64_t'({33'd0, cfg_data[30:0]});
      end
    end
  end

endmodule

>>> verif/boris_particle_push_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boris_particle_push_tb
// Drives particle pushes into the Boris pusher under several charge-to-mass
// and time-step settings, with directed extremes and random particles, and
// lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
module boris_particle_push_tb;
  import bpp_pkg::*;

  localparam int LATENCY   = 22;
  localparam int WDOG_MAX  = 5000;
  localparam int N_PHASES  = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_CHARGE_TO_MASS;
  logic [31:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  q_t          pos_x = '0, pos_y = '0, pos_z = '0;
  q_t          vel_x = '0, vel_y = '0, vel_z = '0;
  q_t          e_x = '0, e_y = '0, e_z = '0;
  q_t          b_x = '0, b_y = '0, b_z = '0;
  logic        done;
  q_t          new_pos_x, new_pos_y, new_pos_z;
  q_t          new_vel_x, new_vel_y, new_vel_z;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          send_gap_pct = 29;

  always #5 clk = ~clk;

  boris_particle_push uut (.*);
  boris_particle_push_chk chk (.*);

  // Watchdog: count cycles with no request and no result accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Pick a field value biased toward the interesting corners.
  function automatic q_t field_val(input int scale);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return q_t'($urandom);
      3: return '0;
      default: return q_t'($signed($urandom) >>> scale);
    endcase
  endfunction

  // One write cycle, then cfg_we low again before the task returns.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold start high until accepted; leave it high for a back-to-back request.
  task automatic push_particle(input q_t f[12]);
    {pos_x, pos_y, pos_z} <= {f[0], f[1], f[2]};
    {vel_x, vel_y, vel_z} <= {f[3], f[4], f[5]};
    {e_x, e_y, e_z} <= {f[6], f[7], f[8]};
    {b_x, b_y, b_z} <= {f[9], f[10], f[11]};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Idle each following cycle with the sender's idle odds.
    while ($urandom_range(0, 99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain the pipeline so the registers can change safely.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    q_t f[12];
    logic [31:0] qm_set[N_PHASES];
    logic [31:0] dt_set[N_PHASES];
    int scale;
    qm_set = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_8000,
               32'h0000_4000, 32'h0000_0000};
    dt_set = '{32'h0000_8000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_1000,
               32'h0000_0000, 32'h0001_0000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers first (dt = 0 passes through), then corners.
    for (int n = 0; n < 4; n++) begin
      foreach (f[i]) f[i] = (n[0]) ? 32'sh7FFFFFFF : 32'sh80000000;
      if (n >= 2) foreach (f[i]) f[i] = q_t'($urandom);
      push_particle(f);
    end
    drain();
    write_reg(REG_CHARGE_TO_MASS, 32'h0001_0000);
    write_reg(REG_TIME_STEP, 32'h0001_0000);
    for (int n = 0; n < 16; n++) begin
      foreach (f[i]) f[i] = '0;
      case (n % 4)
        0: f[9 + n / 4 % 3] = 32'sh0001_0000;            // pure rotation
        1: begin f[6] = 32'sh7FFFFFFF; f[3] = 32'sh7FFFFFFF; end
        2: begin foreach (f[i]) f[i] = 32'sh80000000; end
        3: begin f[9] = 32'sh7FFFFFFF; f[10] = 32'sh7FFFFFFF; f[11] = 32'sh7FFFFFFF;
                 f[3] = 32'sh0100_0000; end            // huge |h|^2
        default: ;
      endcase
      push_particle(f);
    end
    drain();

    // Random phases over several register settings and idle profiles.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_gap_pct = (ph < 2) ? 29 : (ph < 4) ? 65 : 0;
      write_reg(REG_CHARGE_TO_MASS, qm_set[ph]);
      write_reg(REG_TIME_STEP, dt_set[ph]);
      for (int n = 0; n < 200; n++) begin
        scale = $urandom_range(0, 20);
        foreach (f[i]) f[i] = field_val(scale);
        push_particle(f);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
